@@ design/nptc_pkg.sv @@
// Shared types and constants for the near-plane triangle clipper.
`timescale 1ns / 1ps
package nptc_pkg;
  localparam int COLOUR_BITS = 32;
  localparam int CH_BITS = 8;
  localparam int CH_COUNT = 4;

  typedef enum logic [1:0] {
    CASE_NONE  = 2'd0,
    CASE_ONE   = 2'd1,
    CASE_TWO   = 2'd2,
    CASE_ALL   = 2'd3
  } clip_case_t;
endpackage

@@ design/near_plane_triangle_clipper_top.sv @@
// Top level of the near-plane triangle clipper: classify, two crossing lanes, vertex sequencer.
`timescale 1ns / 1ps
// Channel | Dir | tdata fields (low bit up)                       | tuser / tlast
// in_     | in  | v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z c0 c1 c2 | - / -
// out_    | out | out_x out_y out_z out_colour                    | triangle_end / last
// cfg_    | in  | near_distance (31 bits)                          | -
// The pipe has one input stage, FRAC_BITS divider stages and one mix stage.
// Each item then yields 0, 3 or 6 vertices, sent one per cycle while out_tready
// is high from the pipe head: 3 with none or two clipped, 6 with one clipped and
// none with all clipped.
// Reset clears valid bits and near_distance to 1.0; a stalled output freezes the pipe.
module near_plane_triangle_clipper_top #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [9*COORD_BITS+95:0] in_tdata, // v0_x..v2_z, colour0..colour2
  output logic out_tvalid,
  input  logic out_tready,
  output logic [((3*COORD_BITS+32+7)/8)*8-1:0] out_tdata, // out_x out_y out_z out_colour
  output logic out_tuser, // triangle_end
  output logic out_tlast, // last
  input  logic cfg_we,
  input  logic [30:0] cfg_wdata
);
  localparam int CB = COORD_BITS;
  localparam int LAT = FRAC_BITS + 2;
  localparam int OW = ((3*CB+32+7)/8)*8;
  localparam int ZW = (CB > 31 ? CB : 31) + 2;

  logic [30:0] near_r;
  always_ff @(posedge clk) begin
    if (!rst_n) near_r <= 31'd65536;
    else if (cfg_we) near_r <= cfg_wdata;
  end

  // Unpack and classify.
  logic signed [CB-1:0] vx [3], vy [3], vz [3];
  logic [31:0] vc [3];
  logic [2:0] mask;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vx[i] = in_tdata[(3*i)*CB +: CB];
      vy[i] = in_tdata[(3*i+1)*CB +: CB];
      vz[i] = in_tdata[(3*i+2)*CB +: CB];
      vc[i] = in_tdata[9*CB + 32*i +: 32];
      mask[i] = $signed(ZW'(vz[i])) > -$signed(ZW'({1'b0, near_r}));
    end
  end

  logic [1:0] ia, ib, ic;
  nptc_pkg::clip_case_t ccase;
  always_comb begin
    unique case (mask) inside
      3'b010, 3'b011: begin ia = 2'd1; ib = 2'd0; ic = 2'd2; end
      3'b100:         begin ia = 2'd2; ib = 2'd1; ic = 2'd0; end
      3'b101:         begin ia = 2'd2; ib = 2'd0; ic = 2'd1; end
      3'b110:         begin ia = 2'd1; ib = 2'd2; ic = 2'd0; end
      default:        begin ia = 2'd0; ib = 2'd1; ic = 2'd2; end
    endcase
    unique case (mask) inside
      3'b000: ccase = nptc_pkg::CASE_NONE;
      3'b111: ccase = nptc_pkg::CASE_ALL;
      3'b011, 3'b101, 3'b110: ccase = nptc_pkg::CASE_TWO;
      default: ccase = nptc_pkg::CASE_ONE;
    endcase
  end

  // Lane 0 crosses a toward (two clipped: c, one clipped: b); lane 1 crosses toward c.
  logic [1:0] l0p, l0q, l1p, l1q;
  always_comb begin
    l0p = ia; l0q = (ccase == nptc_pkg::CASE_TWO) ? ic : ib;
    l1p = (ccase == nptc_pkg::CASE_TWO) ? ib : ia; l1q = ic;
  end

  // Pipe advances when the head item is absent or sends its final vertex.
  logic adv;
  logic signed [CB-1:0] rx [2], ry [2], rz [2];
  logic [31:0] rc [2];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    nptc_lane #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk, .adv,
      .p_x(vx[l ? l1p : l0p]), .p_y(vy[l ? l1p : l0p]), .p_z(vz[l ? l1p : l0p]),
      .p_col(vc[l ? l1p : l0p]),
      .q_x(vx[l ? l1q : l0q]), .q_y(vy[l ? l1q : l0q]), .q_z(vz[l ? l1q : l0q]),
      .q_col(vc[l ? l1q : l0q]),
      .near_d(near_r), .r_x(rx[l]), .r_y(ry[l]), .r_z(rz[l]), .r_col(rc[l]));
  end

  // Side data travelling beside the lanes: valid, case, and all three verts or b and c.
  typedef struct packed {
    logic vld;
    logic [1:0] cs;
    logic [3*(3*CB+32)-1:0] pass; // v0 v1 v2 (none clipped) or c b c
  } side_t;
  side_t side_r [LAT];
  logic [3*CB+31:0] vb, vc_p, vv [3];
  always_comb begin
    for (int i = 0; i < 3; i++) vv[i] = {vc[i], vz[i], vy[i], vx[i]};
  end
  assign vb = vv[ib];
  assign vc_p = vv[ic];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LAT; s++) side_r[s].vld <= 1'b0;
    end else if (adv) begin
      side_r[0].vld <= in_tvalid && (ccase != nptc_pkg::CASE_ALL);
      for (int s = 1; s < LAT; s++) side_r[s].vld <= side_r[s-1].vld;
    end
    if (adv) begin
      side_r[0].cs <= ccase;
      side_r[0].pass <= (ccase == nptc_pkg::CASE_NONE) ? {vv[2], vv[1], vv[0]} :
                        {vc_p, vb, vc_p};
      for (int s = 1; s < LAT; s++) begin
        side_r[s].cs <= side_r[s-1].cs;
        side_r[s].pass <= side_r[s-1].pass;
      end
    end
  end

  // Vertex sequencer over the pipe head.
  logic [2:0] idx_r;
  logic [2:0] nvtx;
  side_t hd;
  assign hd = side_r[LAT-1];
  assign nvtx = (hd.cs == nptc_pkg::CASE_ONE) ? 3'd6 : 3'd3;
  logic [3*CB+31:0] sel;
  logic tend;
  always_comb begin
    sel = hd.pass[0 +: 3*CB+32];
    case (hd.cs)
      nptc_pkg::CASE_NONE: sel = hd.pass[idx_r[1:0]*(3*CB+32) +: 3*CB+32];
      nptc_pkg::CASE_TWO: begin
        case (idx_r)
          3'd0: sel = {rc[0], rz[0], ry[0], rx[0]};
          3'd1: sel = {rc[1], rz[1], ry[1], rx[1]};
          default: sel = hd.pass[2*(3*CB+32) +: 3*CB+32];
        endcase
      end
      default: begin
        case (idx_r) inside
          3'd0, 3'd3: sel = {rc[0], rz[0], ry[0], rx[0]};
          3'd1: sel = hd.pass[(3*CB+32) +: 3*CB+32];
          3'd4: sel = {rc[1], rz[1], ry[1], rx[1]};
          default: sel = hd.pass[2*(3*CB+32) +: 3*CB+32];
        endcase
      end
    endcase
    tend = (idx_r == 3'd2) || (idx_r == 3'd5);
  end

  logic head_done;
  assign head_done = !hd.vld || ((idx_r == nvtx - 3'd1) && out_tready);
  assign adv = head_done;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else if (hd.vld && out_tready) idx_r <= (idx_r == nvtx - 3'd1) ? 3'd0 : idx_r + 3'd1;
  end

  assign out_tvalid = hd.vld;
  assign out_tdata = OW'(sel);
  assign out_tuser = tend;
  assign out_tlast = (idx_r == nvtx - 3'd1);

  a_idx: assert property (@(posedge clk) disable iff (!rst_n) idx_r < nvtx || !hd.vld)
    else $error("vertex index past end");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(idx_r))
    else $error("index moved under stall");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("last without triangle end");
endmodule

@@ design/nptc_lane.sv @@
// One edge-crossing lane: divider for the crossing fraction, then coordinate and colour mix.
`timescale 1ns / 1ps
module nptc_lane #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         adv,
  input  logic signed [COORD_BITS-1:0] p_x,
  input  logic signed [COORD_BITS-1:0] p_y,
  input  logic signed [COORD_BITS-1:0] p_z,
  input  logic [31:0]                  p_col,
  input  logic signed [COORD_BITS-1:0] q_x,
  input  logic signed [COORD_BITS-1:0] q_y,
  input  logic signed [COORD_BITS-1:0] q_z,
  input  logic [31:0]                  q_col,
  input  logic [30:0]                  near_d,
  output logic signed [COORD_BITS-1:0] r_x,
  output logic signed [COORD_BITS-1:0] r_y,
  output logic signed [COORD_BITS-1:0] r_z,
  output logic [31:0]                  r_col
);
  localparam int WB = (COORD_BITS > 31 ? COORD_BITS : 31) + 2;
  localparam int ST = FRAC_BITS;
  localparam int DB = COORD_BITS + 1;
  localparam int CH_W = nptc_pkg::CH_BITS + FRAC_BITS + 1;

  // Restoring divider pipeline: one quotient bit per stage.
  logic [WB-1:0] rem_r [ST+1];
  logic [WB-1:0] den_r [ST+1];
  logic [FRAC_BITS-1:0] a_r [ST+1];
  logic signed [COORD_BITS-1:0] px_r [ST+1], py_r [ST+1], pz_r [ST+1];
  logic signed [COORD_BITS-1:0] qx_r [ST+1], qy_r [ST+1], qz_r [ST+1];
  logic [31:0] pc_r [ST+1], qc_r [ST+1];

  logic signed [WB-1:0] num_s, den_s;
  logic zero_frac;
  always_comb begin
    num_s = -$signed({2'b00, near_d}) - WB'(q_z);
    den_s = WB'(p_z) - WB'(q_z);
    zero_frac = (den_s <= 0) || (num_s <= 0) || (num_s >= den_s);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= zero_frac ? '0 : num_s;
      den_r[0] <= zero_frac ? {WB{1'b1}} : den_s;
      a_r[0] <= '0;
      px_r[0] <= p_x; py_r[0] <= p_y; pz_r[0] <= p_z; pc_r[0] <= p_col;
      qx_r[0] <= q_x; qy_r[0] <= q_y; qz_r[0] <= q_z; qc_r[0] <= q_col;
    end
  end

  for (genvar s = 0; s < ST; s++) begin : g_div
    logic [WB-1:0] sh;
    logic take;
    assign sh = {rem_r[s][WB-2:0], 1'b0};
    assign take = sh >= den_r[s];
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s+1] <= take ? sh - den_r[s] : sh;
        den_r[s+1] <= den_r[s];
        a_r[s+1] <= {a_r[s][FRAC_BITS-2:0], take};
        px_r[s+1] <= px_r[s]; py_r[s+1] <= py_r[s]; pz_r[s+1] <= pz_r[s];
        qx_r[s+1] <= qx_r[s]; qy_r[s+1] <= qy_r[s]; qz_r[s+1] <= qz_r[s];
        pc_r[s+1] <= pc_r[s]; qc_r[s+1] <= qc_r[s];
      end
    end
  end

  // Mix stage: products registered, then shifted and added.
  logic [FRAC_BITS-1:0] a;
  assign a = a_r[ST];
  logic signed [DB+FRAC_BITS:0] mx_r, my_r, mz_r;
  logic signed [COORD_BITS-1:0] bx_r, by_r, bz_r;
  logic [CH_W-1:0] cp_r [nptc_pkg::CH_COUNT];
  logic [CH_W-1:0] cq_r [nptc_pkg::CH_COUNT];
  logic [FRAC_BITS:0] inv_a;
  assign inv_a = (FRAC_BITS+1)'(1) << FRAC_BITS;

  function automatic logic signed [DB+FRAC_BITS:0] prod(
      input logic signed [COORD_BITS-1:0] p, input logic signed [COORD_BITS-1:0] q,
      input logic [FRAC_BITS-1:0] f);
    logic signed [DB-1:0] d;
    d = DB'(p) - DB'(q);
    return d * $signed({1'b0, f});
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      mx_r <= prod(px_r[ST], qx_r[ST], a);
      my_r <= prod(py_r[ST], qy_r[ST], a);
      mz_r <= prod(pz_r[ST], qz_r[ST], a);
      bx_r <= qx_r[ST]; by_r <= qy_r[ST]; bz_r <= qz_r[ST];
      for (int c = 0; c < nptc_pkg::CH_COUNT; c++) begin
        cp_r[c] <= CH_W'(pc_r[ST][c*8 +: 8]) * CH_W'(a);
        cq_r[c] <= CH_W'(qc_r[ST][c*8 +: 8]) * CH_W'(inv_a - {1'b0, a});
      end
    end
  end

  always_comb begin
    logic [9:0] t;
    r_x = bx_r + COORD_BITS'(mx_r >>> FRAC_BITS);
    r_y = by_r + COORD_BITS'(my_r >>> FRAC_BITS);
    r_z = bz_r + COORD_BITS'(mz_r >>> FRAC_BITS);
    r_col = '0;
    for (int c = 0; c < nptc_pkg::CH_COUNT; c++) begin
      t = 10'(cp_r[c] >> FRAC_BITS) + 10'(cq_r[c] >> FRAC_BITS);
      r_col[c*8 +: 8] = (t > 10'd255) ? 8'hFF : t[7:0];
    end
  end
endmodule

@@ dv/nptc_checker.sv @@
// Checker for the near-plane clipper: tracks the near plane, predicts vertices, compares them.
`timescale 1ns / 1ps
module nptc_checker #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tready,
  input  logic [9*COORD_BITS+95:0] in_tdata,
  input  logic out_tvalid,
  input  logic out_tready,
  input  logic [((3*COORD_BITS+32+7)/8)*8-1:0] out_tdata,
  input  logic out_tuser,
  input  logic out_tlast,
  input  logic cfg_we,
  input  logic [30:0] cfg_wdata,
  output int   fail_count,
  output int   pending_vertices
);
  typedef struct {
    logic signed [63:0] x, y, z;
    logic [31:0] col;
  } vertex_t;

  typedef struct {
    logic [COORD_BITS-1:0] x, y, z;
    logic [31:0] col;
    logic tri_end, last;
  } out_vertex_t;

  out_vertex_t vertex_q[$];
  logic [30:0] near_dist;

  assign pending_vertices = vertex_q.size();

  function automatic logic [63:0] crossing_frac(logic signed [63:0] zp, logic signed [63:0] zq,
                                                logic signed [63:0] n);
    logic signed [63:0] num, den;
    logic [63:0] rem, a;
    num = -n - zq;
    den = zp - zq;
    a = 0;
    if (den <= 0 || num <= 0 || num >= den) return 0;
    rem = num;
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      a = a << 1;
      if (rem >= den) begin
        rem = rem - den;
        a[0] = 1'b1;
      end
    end
    return a;
  endfunction

  // floor((p - q) * a / 2^F) added to q, done exactly in a wide signed product
  function automatic logic signed [63:0] lerp_coord(logic signed [63:0] p, logic signed [63:0] q,
                                                   logic [63:0] a);
    logic signed [127:0] prod;
    prod = 128'(signed'(p - q)) * $signed({64'd0, a});
    return q + 64'(prod >>> FRAC_BITS);
  endfunction

  function automatic logic [31:0] lerp_colour(logic [31:0] cp, logic [31:0] cq, logic [63:0] a);
    logic [63:0] t;
    logic [31:0] r;
    r = 0;
    for (int ch = 0; ch < nptc_pkg::CH_COUNT; ch++) begin
      t = ((64'(cp[ch*8 +: 8]) * a) >> FRAC_BITS) +
          ((64'(cq[ch*8 +: 8]) * ((64'd1 << FRAC_BITS) - a)) >> FRAC_BITS);
      r[ch*8 +: 8] = (t > 255) ? 8'd255 : t[7:0];
    end
    return r;
  endfunction

  function automatic vertex_t crossing(vertex_t p, vertex_t q, logic signed [63:0] n);
    vertex_t r;
    logic [63:0] a;
    a = crossing_frac(p.z, q.z, n);
    r.x = lerp_coord(p.x, q.x, a);
    r.y = lerp_coord(p.y, q.y, a);
    r.z = lerp_coord(p.z, q.z, a);
    r.col = lerp_colour(p.col, q.col, a);
    return r;
  endfunction

  function automatic void push_vertex(vertex_t v, logic tri_end, logic last);
    out_vertex_t o;
    o.x = v.x[COORD_BITS-1:0];
    o.y = v.y[COORD_BITS-1:0];
    o.z = v.z[COORD_BITS-1:0];
    o.col = v.col;
    o.tri_end = tri_end;
    o.last = last;
    vertex_q.push_back(o);
  endfunction

  task automatic clip_triangle(logic [9*COORD_BITS+95:0] d);
    vertex_t v[3];
    vertex_t a, b, c, p1, p2;
    logic signed [63:0] n;
    logic [2:0] mask;
    int cnt;
    n = near_dist;
    mask = 0;
    cnt = 0;
    for (int i = 0; i < 3; i++) begin
      v[i].x = signed'(d[(3*i)*COORD_BITS +: COORD_BITS]);
      v[i].y = signed'(d[(3*i+1)*COORD_BITS +: COORD_BITS]);
      v[i].z = signed'(d[(3*i+2)*COORD_BITS +: COORD_BITS]);
      v[i].col = d[9*COORD_BITS + 32*i +: 32];
      if (v[i].z > -n) begin
        mask[i] = 1'b1;
        cnt++;
      end
    end
    // clipped vertices first; v0,v2 clipped takes (v2,v0,v1)
    case (mask) inside
      3'b010, 3'b011: begin a = v[1]; b = v[0]; c = v[2]; end
      3'b100:         begin a = v[2]; b = v[1]; c = v[0]; end
      3'b101:         begin a = v[2]; b = v[0]; c = v[1]; end
      3'b110:         begin a = v[1]; b = v[2]; c = v[0]; end
      default:        begin a = v[0]; b = v[1]; c = v[2]; end
    endcase
    if (cnt == 0) begin
      push_vertex(v[0], 0, 0);
      push_vertex(v[1], 0, 0);
      push_vertex(v[2], 1, 1);
    end else if (cnt == 2) begin
      push_vertex(crossing(a, c, n), 0, 0);
      push_vertex(crossing(b, c, n), 0, 0);
      push_vertex(c, 1, 1);
    end else if (cnt == 1) begin
      p1 = crossing(a, b, n);
      p2 = crossing(a, c, n);
      push_vertex(p1, 0, 0);
      push_vertex(b, 0, 0);
      push_vertex(c, 1, 0);
      push_vertex(p1, 0, 0);
      push_vertex(p2, 0, 0);
      push_vertex(c, 1, 1);
    end
  endtask

  task automatic compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_vertex_t e;
    if (!rst_n) begin
      near_dist <= 31'd65536;
      fail_count = 0;
    end else begin
      if (cfg_we) near_dist <= cfg_wdata;
      if (in_tvalid && in_tready) clip_triangle(in_tdata);
      if (out_tvalid && out_tready) begin
        if (vertex_q.size() == 0) begin
          $error("vertex out with nothing expected");
          fail_count++;
        end else begin
          e = vertex_q.pop_front();
          compare("out_x", 64'(e.x), 64'(out_tdata[0 +: COORD_BITS]));
          compare("out_y", 64'(e.y), 64'(out_tdata[COORD_BITS +: COORD_BITS]));
          compare("out_z", 64'(e.z), 64'(out_tdata[2*COORD_BITS +: COORD_BITS]));
          compare("out_colour", 64'(e.col), 64'(out_tdata[3*COORD_BITS +: 32]));
          compare("triangle_end", 64'(e.tri_end), 64'(out_tuser));
          compare("last", 64'(e.last), 64'(out_tlast));
        end
      end
    end
  end
endmodule

@@ dv/tb_near_plane_triangle_clipper_top.sv @@
// Testbench top: drives triangles and near-plane settings into the clipper, gives the verdict.
`timescale 1ns / 1ps
module tb_near_plane_triangle_clipper_top;
  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W = 9*COORD_BITS+96;
  localparam int LATENCY = FRAC_BITS + 3;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [DATA_W-1:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [((3*COORD_BITS+32+7)/8)*8-1:0] out_tdata;
  logic out_tuser, out_tlast;
  logic cfg_we;
  logic [30:0] cfg_wdata;
  int fail_count, pending_vertices;
  int send_idle_pct, recv_stall_pct;

  near_plane_triangle_clipper_top #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) dut (.*);

  nptc_checker #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Hang guard: well above 350 items of six stalled vertices each
  initial begin
    #4ms;
    $display("near_plane_triangle_clipper_top verification failed");
    $finish;
  end

  // Stall the receiver at random, decided anew each falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [31:0] rand_z(logic [30:0] n);
    // mostly near the plane so all clip patterns are common
    case ($urandom_range(3))
      0: return $urandom();
      1: return -32'(n) + 32'($signed($urandom_range(8192)) - 4096);
      default: return -32'(n) + 32'($signed($urandom_range(1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_triangle(logic [30:0] n, int span);
    logic [DATA_W-1:0] d;
    for (int i = 0; i < 3; i++) begin
      // small coordinates most of the time, full width now and then
      d[3*i*COORD_BITS +: COORD_BITS] = span ? $urandom() : 32'($signed($urandom_range(1<<20)) - (1<<19));
      d[(3*i+1)*COORD_BITS +: COORD_BITS] = span ? $urandom() : 32'($signed($urandom_range(1<<20)) - (1<<19));
      d[(3*i+2)*COORD_BITS +: COORD_BITS] = rand_z(n);
      d[9*COORD_BITS + 32*i +: 32] = $urandom();
    end
    return d;
  endfunction

  function automatic logic [DATA_W-1:0] pack_tri(logic [31:0] x, logic [31:0] y,
                                                 logic [31:0] z0, logic [31:0] z1,
                                                 logic [31:0] z2, logic [31:0] col);
    return {col, ~col, col, z2, ~y, ~x, z1, y, x, z0, y, x};
  endfunction

  // Hold one item on the bus until it is taken, with random idle before it.
  task automatic send_triangle(logic [DATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Let everything in flight drain before touching the register.
  task automatic set_near(logic [30:0] n);
    in_tvalid <= 1'b0;
    while (pending_vertices != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [30:0] near_vals[6];
    logic [30:0] nd;
    int waited;
    near_vals = '{31'd65536, 31'd0, 31'h7fffffff, 31'd1, 31'd327680, 31'h40000000};
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_we = 0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: every clip pattern, field extremes, saturated colours.
    nd = 31'd65536;
    for (int m = 0; m < 8; m++) begin
      send_triangle(pack_tri($urandom(), $urandom(),
                             m[0] ? 32'h0001_0000 : 32'hfffd_0000,
                             m[1] ? 32'h0002_0000 : 32'hfffc_0000,
                             m[2] ? 32'h0000_8000 : 32'hfff8_0000, $urandom()));
    end
    send_triangle(pack_tri(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                           32'h8000_0000, 32'hffff_0000, 32'hffff_ffff));
    send_triangle(pack_tri(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                           32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000));
    send_triangle(pack_tri(32'hffff_ffff, 32'h0, 32'hffff_0000,
                           32'hffff_0001, 32'hfffe_ffff, 32'hffff_ffff));
    send_triangle('1);
    send_triangle('0);
    set_near(31'd0);
    send_triangle(pack_tri(32'h1234, 32'h5678, 32'h0, 32'h1, 32'hffff_ffff, 32'hff80_ff01));
    set_near(31'h7fffffff);
    send_triangle(pack_tri(32'h1234, 32'h5678, 32'h8000_0000, 32'h8000_0001,
                           32'h8000_0000, 32'hffff_ffff));
    send_triangle(pack_tri(32'h0, 32'h0, 32'h8000_0001, 32'h8000_0000,
                           32'h8000_0001, 32'h00ff_00ff));

    // Random phases: vary idling, stalling and the near plane between them.
    for (int ph = 0; ph < 6; ph++) begin
      nd = near_vals[ph];
      set_near(nd);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 72; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 72; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int i = 0; i < 56; i++) send_triangle(rand_triangle(nd, ($urandom_range(9) == 0)));
    end
    in_tvalid <= 1'b0;

    waited = 0;
    while (pending_vertices != 0 && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0 && pending_vertices == 0) begin
      $display("near_plane_triangle_clipper_top verification clean");
    end else begin
      $display("near_plane_triangle_clipper_top verification failed");
    end
    $finish;
  end
endmodule

@@ near_plane_triangle_clipper_top.f @@
design/nptc_pkg.sv
design/nptc_lane.sv
design/near_plane_triangle_clipper_top.sv
dv/nptc_checker.sv
dv/tb_near_plane_triangle_clipper_top.sv
